// ===== rtl/csim_pkg.sv =====
// ----------------------------------------------------------------------------
// csim_pkg: shared constants and types of the cosine similarity engine
// Widths of the accumulators, the job record between front and back, and
// the sizes of the divide/square-root search.
// ----------------------------------------------------------------------------
`default_nettype none

package csim_pkg;

   localparam int MAX_LENGTH = 1024;
   localparam int CNT_W      = $clog2(MAX_LENGTH + 2);

   localparam int DOT_W   = 42;
   localparam int NORM_W  = 41;
   localparam int MAG_W   = 42;
   localparam int MUL_W   = 2 * MAG_W;
   localparam int MULC_W  = $clog2(MAG_W + 1);
   localparam int WIDE_W  = 116;
   localparam int RES_W   = 16;
   localparam int STEP_W  = 4;
   localparam int FIFO_DEPTH = 2;
   localparam int LVL_W   = $clog2(FIFO_DEPTH + 1);

   typedef struct packed {
      logic signed [DOT_W-1:0] dot;
      logic [NORM_W-1:0]       norm_a;
      logic [NORM_W-1:0]       norm_b;
      logic                    ovf;
   } csim_job_type;

endpackage

`default_nettype wire

// ===== rtl/csim_ifs.sv =====
// ----------------------------------------------------------------------------
// csim_ifs: stream channels of the cosine similarity engine
// Valid/ready channels for element pairs and for similarity results.
// ----------------------------------------------------------------------------
`default_nettype none

interface csim_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] elem_a;
   logic signed [15:0] elem_b;
   logic               last_elem;
   modport source (output valid, output elem_a, output elem_b, output last_elem,
                   input ready);
   modport sink   (input valid, input elem_a, input elem_b, input last_elem,
                   output ready);
endinterface

interface csim_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] similarity;
   logic               zero_norm;
   logic               length_overflow;
   modport source (output valid, output similarity, output zero_norm,
                   output length_overflow, input ready);
   modport sink   (input valid, input similarity, input zero_norm,
                   input length_overflow, output ready);
endinterface

`default_nettype wire

// ===== rtl/csim_front.sv =====
// ----------------------------------------------------------------------------
// csim_front: multiply-accumulate front end
// Takes a pair per cycle while the job queue has room, squares and multiplies
// in one stage, accumulates saturating in the next; a last pair emits a job.
// ----------------------------------------------------------------------------
`default_nettype none

module csim_front (
   input  wire                          clock,
   input  wire                          reset,
   csim_req_if.sink                     req,
   input  wire [csim_pkg::LVL_W-1:0]    fifo_level,
   output logic                         job_push,
   output csim_pkg::csim_job_type       job_data
);
   import csim_pkg::*;

   logic                     s1_valid_ff, s1_valid_in;
   logic                     s1_last_ff;
   logic signed [31:0]       prod_ab_ff;
   logic [30:0]              sq_a_ff;
   logic [30:0]              sq_b_ff;
   logic signed [DOT_W-1:0]  dot_ff, dot_in;
   logic [NORM_W-1:0]        na_ff, na_in;
   logic [NORM_W-1:0]        nb_ff, nb_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [DOT_W:0]    dot_sum;
   logic [NORM_W:0]          na_sum;
   logic [NORM_W:0]          nb_sum;
   logic signed [DOT_W-1:0]  dot_sat;
   logic [NORM_W-1:0]        na_sat;
   logic [NORM_W-1:0]        nb_sat;
   logic [CNT_W-1:0]         cnt_next;
   logic                     accept;
   logic [LVL_W:0]           reserved;

   localparam logic signed [DOT_W:0] DotMax = (DOT_W+1)'((64'sd1 <<< (DOT_W-1)) - 1);
   localparam logic signed [DOT_W:0] DotMin = -DotMax - 1;

   // A last pair still in the product stage holds a queue slot in reserve.
   assign reserved  = {1'b0, fifo_level} + (LVL_W+1)'(s1_valid_ff & s1_last_ff);
   assign req.ready = reserved < (LVL_W+1)'(FIFO_DEPTH);
   assign accept    = req.valid & req.ready;
   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_last_ff <= req.last_elem;
         prod_ab_ff <= req.elem_a * req.elem_b;
         sq_a_ff    <= 31'(req.elem_a * req.elem_a);
         sq_b_ff    <= 31'(req.elem_b * req.elem_b);
      end
   end

   always_comb begin
      dot_sum = {dot_ff[DOT_W-1], dot_ff} + (DOT_W+1)'(prod_ab_ff);
      if (dot_sum > DotMax) begin
         dot_sat = DotMax[DOT_W-1:0];
      end else if (dot_sum < DotMin) begin
         dot_sat = DotMin[DOT_W-1:0];
      end else begin
         dot_sat = dot_sum[DOT_W-1:0];
      end
      na_sum = {1'b0, na_ff} + (NORM_W+1)'(sq_a_ff);
      nb_sum = {1'b0, nb_ff} + (NORM_W+1)'(sq_b_ff);
      na_sat = na_sum[NORM_W] ? '1 : na_sum[NORM_W-1:0];
      nb_sat = nb_sum[NORM_W] ? '1 : nb_sum[NORM_W-1:0];
      cnt_next = (cnt_ff <= CNT_W'(MAX_LENGTH)) ? cnt_ff + 1'b1 : cnt_ff;

      job_push        = s1_valid_ff & s1_last_ff;
      job_data.dot    = dot_sat;
      job_data.norm_a = na_sat;
      job_data.norm_b = nb_sat;
      job_data.ovf    = cnt_next > CNT_W'(MAX_LENGTH);

      dot_in = dot_ff;
      na_in  = na_ff;
      nb_in  = nb_ff;
      cnt_in = cnt_ff;
      if (s1_valid_ff) begin
         if (s1_last_ff) begin
            dot_in = '0;
            na_in  = '0;
            nb_in  = '0;
            cnt_in = '0;
         end else begin
            dot_in = dot_sat;
            na_in  = na_sat;
            nb_in  = nb_sat;
            cnt_in = cnt_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         dot_ff      <= '0;
         na_ff       <= '0;
         nb_ff       <= '0;
         cnt_ff      <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         dot_ff      <= dot_in;
         na_ff       <= na_in;
         nb_ff       <= nb_in;
         cnt_ff      <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/csim_fifo.sv =====
// ----------------------------------------------------------------------------
// csim_fifo: job queue between front and back
// Two-entry register queue of finished accumulations.
// ----------------------------------------------------------------------------
`default_nettype none

module csim_fifo (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  csim_pkg::csim_job_type       push_data,
   input  wire                          pop,
   output logic                         pop_valid,
   output csim_pkg::csim_job_type       pop_data,
   output logic [csim_pkg::LVL_W-1:0]   level
);
   import csim_pkg::*;

   csim_job_type      mem_ff [FIFO_DEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [LVL_W-1:0]  level_ff, level_in;
   logic              do_pop;

   assign do_pop    = pop & (level_ff != '0);
   assign pop_valid = level_ff != '0;
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign level     = level_ff;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      level_in  = level_ff + LVL_W'(push) - LVL_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      level_ff == LVL_W'(FIFO_DEPTH) |-> !push || do_pop)
      else $error("job pushed into a full queue");
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LVL_W'(FIFO_DEPTH))
      else $error("queue level out of range");
   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      level_ff == '0 |-> wr_ptr_ff == rd_ptr_ff)
      else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// ===== rtl/csim_back.sv =====
// ----------------------------------------------------------------------------
// csim_back: similarity sequencer
// Forms normA*normB and dot^2 on a shift-add multiplier, then finds the
// quotient of the square root bit by bit, and holds the result for output.
// ----------------------------------------------------------------------------
`default_nettype none

module csim_back (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          job_valid,
   input  csim_pkg::csim_job_type       job_data,
   output logic                         job_pop,
   csim_rsp_if.source                   rsp
);
   import csim_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MULP = 3'd1;
   localparam logic [2:0] ST_MULR = 3'd2;
   localparam logic [2:0] ST_SRCH = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [MUL_W-1:0]    mc_ff, mc_in;
   logic [MAG_W-1:0]    mp_ff, mp_in;
   logic [MUL_W-1:0]    acc_ff, acc_in;
   logic [MULC_W-1:0]   mcnt_ff, mcnt_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                neg_ff, neg_in;
   logic                zero_ff, zero_in;
   logic                ovf_ff, ovf_in;
   logic [WIDE_W-1:0]   p_ff, p_in;
   logic [WIDE_W-1:0]   r_ff, r_in;
   logic [WIDE_W-1:0]   s_ff, s_in;
   logic [WIDE_W-1:0]   a_ff, a_in;
   logic [WIDE_W-1:0]   b_ff, b_in;
   logic [STEP_W-1:0]   k_ff, k_in;
   logic [RES_W-1:0]    res_ff, res_in;
   logic                out_valid_ff, out_valid_in;
   logic signed [RES_W-1:0] out_sim_ff, out_sim_in;
   logic                out_zero_ff, out_zero_in;
   logic                out_ovf_ff, out_ovf_in;
   logic [WIDE_W-1:0]   cand;
   logic                take;
   logic [WIDE_W-1:0]   a_upd;
   logic [MUL_W-1:0]    acc_add;
   logic                mul_last;
   logic                out_free;

   assign rsp.valid           = out_valid_ff;
   assign rsp.similarity      = out_sim_ff;
   assign rsp.zero_norm       = out_zero_ff;
   assign rsp.length_overflow = out_ovf_ff;

   assign out_free = !out_valid_ff || rsp.ready;
   assign job_pop  = (state_ff == ST_IDLE) && job_valid;

   always_comb begin
      acc_add  = acc_ff + (mp_ff[0] ? mc_ff : '0);
      mul_last = mcnt_ff == MULC_W'(MAG_W - 1);
      cand     = s_ff + a_ff + b_ff;
      take     = (cand <= r_ff) && !res_ff[RES_W-1];
      a_upd    = take ? a_ff + (b_ff << 1) : a_ff;

      state_in = state_ff;
      mc_in    = mc_ff;
      mp_in    = mp_ff;
      acc_in   = acc_ff;
      mcnt_in  = mcnt_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      zero_in  = zero_ff;
      ovf_in   = ovf_ff;
      p_in     = p_ff;
      r_in     = r_ff;
      s_in     = s_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      k_in     = k_ff;
      res_in   = res_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      out_sim_in   = out_sim_ff;
      out_zero_in  = out_zero_ff;
      out_ovf_in   = out_ovf_ff;

      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               neg_in  = job_data.dot < 0;
               mag_in  = job_data.dot < 0 ? MAG_W'(-job_data.dot) : MAG_W'(job_data.dot);
               zero_in = (job_data.norm_a == '0) || (job_data.norm_b == '0);
               ovf_in  = job_data.ovf;
               res_in  = '0;
               mc_in   = MUL_W'(job_data.norm_a);
               mp_in   = MAG_W'(job_data.norm_b);
               acc_in  = '0;
               mcnt_in = '0;
               state_in = ((job_data.norm_a == '0) || (job_data.norm_b == '0))
                          ? ST_DONE : ST_MULP;
            end
         end
         ST_MULP: begin
            acc_in  = acc_add;
            mc_in   = mc_ff << 1;
            mp_in   = mp_ff >> 1;
            mcnt_in = mcnt_ff + 1'b1;
            if (mul_last) begin
               p_in     = WIDE_W'(acc_add);
               mc_in    = MUL_W'(mag_ff);
               mp_in    = mag_ff;
               acc_in   = '0;
               mcnt_in  = '0;
               state_in = ST_MULR;
            end
         end
         ST_MULR: begin
            acc_in  = acc_add;
            mc_in   = mc_ff << 1;
            mp_in   = mp_ff >> 1;
            mcnt_in = mcnt_ff + 1'b1;
            if (mul_last) begin
               r_in     = WIDE_W'(acc_add) << 30;
               s_in     = '0;
               a_in     = '0;
               b_in     = p_ff << 30;
               k_in     = STEP_W'(RES_W - 1);
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            // s is r^2*P, a is r*P<<(k+1), b is P<<2k for the current bit k.
            if (take) begin
               s_in   = cand;
               res_in = res_ff | (RES_W'(1) << k_ff);
            end
            a_in = a_upd >> 1;
            b_in = b_ff >> 2;
            k_in = k_ff - 1'b1;
            if (k_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_zero_in  = zero_ff;
               out_ovf_in   = ovf_ff;
               if (zero_ff) begin
                  out_sim_in = '0;
               end else if (neg_ff) begin
                  out_sim_in = -$signed(res_ff);
               end else if (res_ff[RES_W-1]) begin
                  out_sim_in = RES_W'(16'sd32767);
               end else begin
                  out_sim_in = $signed(res_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mc_ff   <= mc_in;
      mp_ff   <= mp_in;
      acc_ff  <= acc_in;
      mcnt_ff <= mcnt_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
      ovf_ff  <= ovf_in;
      p_ff    <= p_in;
      r_ff    <= r_in;
      s_ff    <= s_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      k_ff    <= k_in;
      res_ff  <= res_in;
      out_sim_ff  <= out_sim_in;
      out_zero_ff <= out_zero_in;
      out_ovf_ff  <= out_ovf_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_zero_ff |-> out_sim_ff == '0)
      else $error("zero norm result is not zero");
   a_res_cap: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SRCH && res_ff[RES_W-1] |-> res_ff[RES_W-2:0] == '0)
      else $error("quotient search exceeded full scale");
   a_search_le: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SRCH |-> s_ff <= r_ff)
      else $error("accepted square exceeds bound");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      job_pop |=> state_ff != ST_SRCH)
      else $error("job taken while busy");

endmodule

`default_nettype wire

// ===== rtl/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine: streaming cosine similarity of two vectors
// Accumulates dot product and sums of squares and returns the Q1.15 cosine.
// ----------------------------------------------------------------------------
// The engine takes one element pair per transaction on the request channel,
// one transaction every clock cycle while ready is high, and accumulates the
// dot product and the two sums of squares exactly with saturation. The pair
// marked last_elem closes the vectors and queues a job. The pair then passes
// the product stage and the job queue; the sequencer takes the job, runs two
// passes of the shift-add multiplier that form normA*normB and dot^2, then a
// bit-by-bit quotient search, and loads the output register, where the
// response transaction carrying the similarity becomes valid. A zero vector
// skips the arithmetic. The sequencer works on one vector at a time, and
// that sets the throughput of vectors. For vectors long enough that the
// sequencer keeps up, the request side streams without a stall, and two
// finished vectors can wait in the job queue. Shorter vectors stall the
// request side once the queue is full. A result of exactly +1.0 reads as
// 32767, a zero vector gives 0 with zero_norm set, and more than
// MAX_LENGTH pairs set length_overflow.
// ----------------------------------------------------------------------------
`default_nettype none

module cosine_similarity_engine (
   input  wire         clock,
   input  wire         reset,
   csim_req_if.sink    req_chan,
   csim_rsp_if.source  rsp_chan
);
   import csim_pkg::*;

   logic              job_push;
   csim_job_type      job_push_data;
   logic              job_pop;
   logic              job_valid;
   csim_job_type      job_data;
   logic [LVL_W-1:0]  fifo_level;

   csim_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .fifo_level (fifo_level),
      .job_push   (job_push),
      .job_data   (job_push_data)
   );

   csim_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_push_data),
      .pop       (job_pop),
      .pop_valid (job_valid),
      .pop_data  (job_data),
      .level     (fifo_level)
   );

   csim_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp       (rsp_chan)
   );

endmodule

`default_nettype wire
